// ----- hw/rtl/freeze_watch_table_assert.svh -----
// Assertion macros used by the freeze watch table top level.
`ifndef FREEZE_WATCH_TABLE_ASSERT_SVH
`define FREEZE_WATCH_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Plain property, checked every cycle outside reset.
`define FWT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("freeze_watch_table: assertion failed");
// Antecedent this cycle, consequent the cycle after.
`define FWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("freeze_watch_table: assertion failed");
`else
`define FWT_ASSERT(label, clk, rst, prop)
`define FWT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/fwt_pkg.sv -----
// Types, codes and constants for the freeze watch table.
package fwt_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 32;
   localparam int ADDR_W  = 64;
   localparam int VALUE_W = 64;
   localparam int WIDTH_W = 4;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int INDEX_W = 6;

   localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_FREEZE = 3'd2;
   localparam logic [OP_W-1:0] OP_FIND       = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_PRESENT = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [ADDR_W-1:0]  lookup_addr;
      logic [WIDTH_W-1:0] width_bytes;
      logic               freeze_enable;
      logic [VALUE_W-1:0] freeze_value_in;
   } req_word_type;

   typedef struct packed {
      logic               result_kind;
      logic [STAT_W-1:0]  status;
      logic [INDEX_W-1:0] found_index;
      logic [ADDR_W-1:0]  write_addr;
      logic [WIDTH_W-1:0] write_width;
      logic [VALUE_W-1:0] write_value;
      logic               last;
   } rsp_word_type;

   // One table entry as held in a cell.
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [WIDTH_W-1:0] width;
      logic               frozen;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // Per-cell command: take neighbor, load from bus, update freeze fields.
   typedef struct packed {
      logic shift;
      logic load;
      logic setf;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY,
      ST_ROTATE
   } state_type;

endpackage

// ----- hw/rtl/fwt_cell.sv -----
// One table cell: holds an entry, compares its address, passes it to the neighbor.
module fwt_cell (
   input  logic                      clock,
   input  fwt_pkg::cell_ctrl_type    ctrl,
   input  logic [fwt_pkg::ADDR_W-1:0] key,
   input  fwt_pkg::entry_type        bus_entry,
   input  fwt_pkg::entry_type        next_entry,
   output fwt_pkg::entry_type        entry,
   output logic                      hit
);
   import fwt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = next_entry;
      end else if (ctrl.load) begin
         entry_in = bus_entry;
      end else if (ctrl.setf) begin
         entry_in.frozen = bus_entry.frozen;
         entry_in.value  = bus_entry.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign hit   = (entry_ff.addr == key);

endmodule

// ----- hw/rtl/freeze_watch_table.sv -----
// Top level of the freeze watch table: control sequencer over a ring of cells.
//
// Freeze watch table. Keeps up to MAX_ENTRIES watched addresses, one per cell, in a
// ring of cells that each pass their entry to the next lower cell when told to shift.
// One request word is taken at a time; req_stall stays high until its work is done.
// Add, remove, set freeze, find, non-rotating ticks and unknown opcodes pass through
// the idle state, in which the request is captured, the match state, in which every
// cell compares its address against the key (the hit vector is registered), and the
// apply state, which applies the change and loads the status word into the response
// register once it is free. A tick with a target attached and any frozen entry instead
// rotates the whole ring once after the apply state, emitting a write word each time a
// frozen entry reaches the head cell; the ring is back in place when the rotation ends.
// Each response word waits in an output register, so rotation only pauses when a write
// word is due and that register is still held by rsp_stall. target_attached is written
// through csr_wr_en / csr_wr_data and should only change while the block is idle. Table
// contents are not cleared by reset; only entry_count is, and entries beyond it are
// never used.
module freeze_watch_table #(
   parameter int MAX_ENTRIES = fwt_pkg::DEFAULT_MAX_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fwt_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output fwt_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);
   import fwt_pkg::*;

`include "freeze_watch_table_assert.svh"

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type              state_ff, state_in;
   logic                   attached_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   req_word_type           req_ff;                 // captured request word
   logic [MAX_ENTRIES-1:0] hit_ff, hit_in;         // occupied cells matching the key
   logic [IDX_W-1:0]       idx_ff, idx_in;         // position of the match
   logic [MAX_ENTRIES-1:0] rem_ff, rem_in;         // frozen entries still to pass head
   logic [IDX_W-1:0]       step_ff, step_in;       // rotation step
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;

   // ---------------------------------------------------------------
   // Cell row
   // ---------------------------------------------------------------
   entry_type              cell_entry [MAX_ENTRIES];
   cell_ctrl_type          cell_ctrl  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] hit_raw;
   logic [MAX_ENTRIES-1:0] occ;
   entry_type              bus_entry;

   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      localparam int NXT = (g + 1) % MAX_ENTRIES;
      fwt_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[g]),
         .key        (req_ff.lookup_addr),
         .bus_entry  (bus_entry),
         .next_entry (cell_entry[NXT]),
         .entry      (cell_entry[g]),
         .hit        (hit_raw[g])
      );
   end

   // Cells at positions below the count hold live entries.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         occ[i] = (CNT_W'(i) < count_ff);
      end
   end

   // Shared load bus: a new entry starts unfrozen with value zero; set freeze
   // carries the new flag and value.
   always_comb begin
      bus_entry.addr   = req_ff.lookup_addr;
      bus_entry.width  = req_ff.width_bytes;
      bus_entry.frozen = (req_ff.opcode == OP_SET_FREEZE) ? req_ff.freeze_enable : 1'b0;
      bus_entry.value  = (req_ff.opcode == OP_SET_FREEZE) ? req_ff.freeze_value_in
                                                          : '0;
   end

   // ---------------------------------------------------------------
   // Decode helpers
   // ---------------------------------------------------------------
   logic                   found;
   logic                   full;
   logic [MAX_ENTRIES-1:0] frz_mask;
   logic                   tick_go;
   logic                   out_free;
   logic                   adv;
   logic                   rot_done;
   logic [IDX_W-1:0]       idx_comb;

   assign found    = |hit_ff;
   assign full     = (count_ff == CNT_W'(MAX_ENTRIES));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         frz_mask[i] = occ[i] & cell_entry[i].frozen;
      end
   end

   assign tick_go  = (req_ff.opcode == OP_TICK) && attached_ff && (|frz_mask);
   // Head cell only needs the output when it holds a frozen entry.
   assign adv      = !rem_ff[0] || out_free;
   assign rot_done = adv && (step_ff == IDX_W'(MAX_ENTRIES - 1));

   // Addresses are unique in the table, so the hit vector is one-hot or empty.
   always_comb begin
      idx_comb = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (hit_raw[i] && occ[i]) begin
            idx_comb = idx_comb | IDX_W'(i);
         end
      end
   end

   // ---------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (tick_go) begin
               state_in = ST_ROTATE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_ROTATE: begin
            if (rot_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Outputs and datapath control
   // ---------------------------------------------------------------
   logic         rsp_load;
   rsp_word_type rsp_next;
   logic         add_ok;
   logic         rem_ok;
   logic         setf_ok;
   logic         rot_shift;

   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      rsp_next  = '0;
      add_ok    = 1'b0;
      rem_ok    = 1'b0;
      setf_ok   = 1'b0;
      rot_shift = 1'b0;
      count_in  = count_ff;
      hit_in    = hit_ff;
      idx_in    = idx_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_MATCH: begin
            hit_in = hit_raw & occ;
            idx_in = idx_comb;
         end
         ST_APPLY: begin
            if (tick_go) begin
               rem_in  = frz_mask;
               step_in = '0;
            end else if (out_free) begin
               rsp_load             = 1'b1;
               rsp_next.result_kind = KIND_STATUS;
               rsp_next.status      = STAT_OK;
               rsp_next.last        = 1'b1;
               case (req_ff.opcode)
                  OP_ADD: begin
                     if (full) begin
                        rsp_next.status = STAT_FULL;
                     end else if (found) begin
                        rsp_next.status = STAT_PRESENT;
                     end else begin
                        add_ok   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (!found) begin
                        rsp_next.status = STAT_MISSING;
                     end else begin
                        rem_ok   = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_SET_FREEZE: begin
                     if (!found) begin
                        rsp_next.status = STAT_MISSING;
                     end else begin
                        setf_ok = 1'b1;
                     end
                  end
                  OP_FIND: begin
                     if (!found) begin
                        rsp_next.status = STAT_MISSING;
                     end else begin
                        rsp_next.found_index = INDEX_W'(idx_ff);
                     end
                  end
                  default: begin
                     // idle tick and unused opcodes answer ok
                  end
               endcase
            end
         end
         ST_ROTATE: begin
            if (adv) begin
               rot_shift = 1'b1;
               rem_in    = rem_ff >> 1;
               step_in   = step_ff + 1'b1;
               if (rem_ff[0]) begin
                  rsp_load             = 1'b1;
                  rsp_next.result_kind = KIND_WRITE;
                  rsp_next.status      = STAT_OK;
                  rsp_next.write_addr  = cell_entry[0].addr;
                  rsp_next.write_width = cell_entry[0].width;
                  rsp_next.write_value = cell_entry[0].value;
                  rsp_next.last        = ((rem_ff >> 1) == '0);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Per-cell commands. Remove pulls every cell at or above the match down one.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         cell_ctrl[i].shift = rot_shift || (rem_ok && (IDX_W'(i) >= idx_ff));
         cell_ctrl[i].load  = add_ok && (count_ff == CNT_W'(i));
         cell_ctrl[i].setf  = setf_ok && hit_ff[i];
      end
   end

   // Response register: loads when free or being taken this cycle.
   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = rsp_next;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------
   // Sequential
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         attached_ff  <= 1'b0;
         count_ff     <= '0;
         hit_ff       <= '0;
         rem_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rem_ff       <= rem_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attached_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_word;
      end
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Stored addresses are unique, so at most one cell matches.
   `FWT_ASSERT(a_unique_hit, clock, reset, $onehot0(hit_ff))
   // Entry count never exceeds the table.
   `FWT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES))
   // Last rotation step has no frozen entry left behind the head.
   `FWT_ASSERT(a_rot_drained, clock, reset,
      !(state_ff == ST_ROTATE && rot_done) || ((rem_ff >> 1) == '0))
   // A successful add grows the table by exactly one.
   `FWT_ASSERT_NEXT(a_add_grows, clock, reset, add_ok,
      count_ff == $past(count_ff) + 1'b1)

endmodule
